### sv/dmxp_pkg.sv
// ----------------------------------------------------------------------------
// dmxp_pkg
// shared types and constants of the widget receive packet parser
// ----------------------------------------------------------------------------
package dmxp_pkg;

  localparam logic [7:0] START_BYTE_RESET = 8'd126;
  localparam logic [7:0] END_BYTE_RESET   = 8'd231;

  localparam logic [7:0] LBL_CONFIG = 8'd3;
  localparam logic [7:0] LBL_FRAME  = 8'd5;
  localparam logic [7:0] LBL_UPDATE = 8'd9;
  localparam logic [7:0] LBL_SERIAL = 8'd10;

  localparam int CONFIG_BYTES = 5;
  localparam int SERIAL_BYTES = 4;

  typedef enum logic [1:0] {
    CFG_FILTER = 2'd0,
    CFG_START  = 2'd1,
    CFG_END    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_FRAME  = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_CONFIG = 3'd2,
    KIND_SERIAL = 3'd3,
    KIND_ERROR  = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  typedef struct packed {
    logic       filter_enable;
    logic [7:0] start_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    kind_t       result_kind;
    logic        new_data;
    logic [7:0]  rx_quality;
    logic [7:0]  frame_start_code;
    logic [15:0] payload_length;
    logic [7:0]  firmware_major;
    logic [7:0]  firmware_minor;
    logic [7:0]  break_time;
    logic [7:0]  mark_after_break;
    logic [7:0]  frame_rate;
    logic [31:0] serial_number;
    logic [7:0]  channel_value;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic    chan_rd;
    result_t res;
  } stage_t;

endpackage

### sv/dmxp_in_if.sv
// ----------------------------------------------------------------------------
// dmxp_in_if
// input channel: received byte or channel read command
// ----------------------------------------------------------------------------
interface dmxp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [9:0] channel_index;

  modport source (output valid, command, rx_byte, channel_index, input ready);
  modport sink (input valid, command, rx_byte, channel_index, output ready);
endinterface

### sv/dmxp_out_if.sv
// ----------------------------------------------------------------------------
// dmxp_out_if
// result channel: one parsed packet or channel read
// ----------------------------------------------------------------------------
interface dmxp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic        new_data;
  logic [7:0]  rx_quality;
  logic [7:0]  frame_start_code;
  logic [15:0] payload_length;
  logic [7:0]  firmware_major;
  logic [7:0]  firmware_minor;
  logic [7:0]  break_time;
  logic [7:0]  mark_after_break;
  logic [7:0]  frame_rate;
  logic [31:0] serial_number;
  logic [7:0]  channel_value;

  modport source (
    output valid, result_kind, new_data, rx_quality, frame_start_code, payload_length,
           firmware_major, firmware_minor, break_time, mark_after_break, frame_rate,
           serial_number, channel_value,
    input  ready
  );
  modport sink (
    input  valid, result_kind, new_data, rx_quality, frame_start_code, payload_length,
           firmware_major, firmware_minor, break_time, mark_after_break, frame_rate,
           serial_number, channel_value,
    output ready
  );
endinterface

### sv/dmx_widget_rx_packet_parser_top.sv
// ----------------------------------------------------------------------------
// dmx_widget_rx_packet_parser_top
// a result is registered in s2, then out_r, after the byte or read is accepted
// throughput: one item per cycle unless out_ch stalls, set by read-first memory
// reset: after rst_n the slot memory is swept to zero, one slot per cycle,
// all UNIVERSE_CHANNELS + 1 slots with in_ch.ready low; config writes are taken
// ----------------------------------------------------------------------------
module dmx_widget_rx_packet_parser_top
  import dmxp_pkg::*;
#(
  parameter int UNIVERSE_CHANNELS = 512,
  parameter int MASK_BYTES = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  dmxp_in_if.sink    in_ch,
  dmxp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(UNIVERSE_CHANNELS + 1);

  cfg_t    cfg_r;
  result_t out_r;
  logic    out_valid_r;

  stage_t        s2;
  logic          busy;
  logic          out_load;
  logic          in_ready;
  logic          accept;
  logic          mem_rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    rd_data;
  result_t       out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable <= 1'b0;
      cfg_r.start_byte    <= START_BYTE_RESET;
      cfg_r.end_byte      <= END_BYTE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILTER: cfg_r.filter_enable <= cfg_wdata[0];
        CFG_START:  cfg_r.start_byte    <= cfg_wdata;
        CFG_END:    cfg_r.end_byte      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_load = ~out_valid_r | out_ch.ready;
    in_ready = ~busy & (~s2.valid | out_load);
    accept   = in_ch.valid & in_ready;
    out_nxt  = s2.res;
    out_nxt.channel_value = s2.chan_rd ? rd_data : 8'd0;
  end

  dmxp_parser #(
    .UNIVERSE_CHANNELS (UNIVERSE_CHANNELS),
    .MASK_BYTES        (MASK_BYTES),
    .AW                (AW)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .adv           (out_load),
    .command       (in_ch.command),
    .rx_byte       (in_ch.rx_byte),
    .channel_index (in_ch.channel_index),
    .rd_data       (rd_data),
    .mem_rd_en     (mem_rd_en),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .s2            (s2)
  );

  dmxp_store #(
    .UNIVERSE_CHANNELS (UNIVERSE_CHANNELS),
    .AW                (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (rd_data),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2.valid) begin
      out_r <= out_nxt;
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_kind      = out_r.result_kind;
  assign out_ch.new_data         = out_r.new_data;
  assign out_ch.rx_quality       = out_r.rx_quality;
  assign out_ch.frame_start_code = out_r.frame_start_code;
  assign out_ch.payload_length   = out_r.payload_length;
  assign out_ch.firmware_major   = out_r.firmware_major;
  assign out_ch.firmware_minor   = out_r.firmware_minor;
  assign out_ch.break_time       = out_r.break_time;
  assign out_ch.mark_after_break = out_r.mark_after_break;
  assign out_ch.frame_rate       = out_r.frame_rate;
  assign out_ch.serial_number    = out_r.serial_number;
  assign out_ch.channel_value    = out_r.channel_value;

endmodule

### sv/dmxp_store.sv
// ----------------------------------------------------------------------------
// dmxp_store
// universe slot memory, read-first single port, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module dmxp_store #(
  parameter int UNIVERSE_CHANNELS = 512,
  parameter int AW = $clog2(UNIVERSE_CHANNELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rd_data,
  output logic          busy
);

  localparam logic [AW-1:0] LAST = AW'(UNIVERSE_CHANNELS);

  logic [7:0]    mem [0:UNIVERSE_CHANNELS];
  logic [7:0]    rd_data_r;
  logic          busy_r;
  logic [AW-1:0] clr_cnt_r;

  logic          en;
  logic          wr;
  logic [AW-1:0] a;
  logic [7:0]    d;

  always_comb begin
    en = busy_r | rd_en;
    wr = busy_r | we;
    a  = busy_r ? clr_cnt_r : addr;
    d  = busy_r ? 8'd0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= mem[a];
      if (wr) begin
        mem[a] <= d;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

### sv/dmxp_parser.sv
// ----------------------------------------------------------------------------
// dmxp_parser
// packet state machine, slot address generation and result stage register
// ----------------------------------------------------------------------------
module dmxp_parser
  import dmxp_pkg::*;
#(
  parameter int UNIVERSE_CHANNELS = 512,
  parameter int MASK_BYTES = 5,
  parameter int AW = $clog2(UNIVERSE_CHANNELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          accept,
  input  logic          adv,
  input  logic          command,
  input  logic [7:0]    rx_byte,
  input  logic [9:0]    channel_index,
  input  logic [7:0]    rd_data,
  output logic          mem_rd_en,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [7:0]    mem_wdata,
  output stage_t        s2
);

  localparam int MW = 8 * MASK_BYTES;
  localparam int IW = $clog2(MW);
  localparam logic [15:0] UC16 = 16'(UNIVERSE_CHANNELS);
  localparam logic [11:0] UC12 = 12'(UNIVERSE_CHANNELS);
  localparam logic [9:0]  UC10 = 10'(UNIVERSE_CHANNELS);

  typedef enum logic [2:0] {
    PH_HUNT, PH_LABEL, PH_LEN_LO, PH_LEN_HI, PH_BODY, PH_END
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  label_r, label_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  quality_r, quality_nxt;
  logic        changed_r, changed_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [MW-1:0] mask_r, mask_nxt;
  logic [39:0] cap_r, cap_nxt;
  logic [31:0] ser_r, ser_nxt;
  logic [7:0]  slot0_r, slot0_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  pend_val_r, pend_val_nxt;
  stage_t      s2_r, s2_nxt;

  logic          changed_cur;
  logic [15:0]   fslot;
  logic [15:0]   pos_inc;
  logic [15:0]   len_full;
  logic [MW-1:0] low;
  logic [IW-1:0] bit_idx;
  logic [11:0]   uslot;
  logic          wr;
  logic [AW-1:0] waddr;
  result_t       res;
  logic          res_v;

  always_comb begin
    changed_cur = changed_r | (pend_r & (rd_data != pend_val_r));
    fslot    = pos_r - 16'd1;
    pos_inc  = pos_r + 16'd1;
    len_full = {rx_byte, len_r[7:0]};
    low      = mask_r & (~mask_r + MW'(1));
    bit_idx  = '0;
    for (int i = 0; i < MW; i++) begin
      if (low[i]) begin
        bit_idx = bit_idx | IW'(i);
      end
    end
    uslot = {1'b0, block_r, 3'b000} + 12'(bit_idx);

    phase_nxt    = phase_r;
    label_nxt    = label_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    quality_nxt  = quality_r;
    changed_nxt  = changed_cur;
    block_nxt    = block_r;
    mask_nxt     = mask_r;
    cap_nxt      = cap_r;
    ser_nxt      = ser_r;
    slot0_nxt    = slot0_r;
    pend_nxt     = 1'b0;
    pend_val_nxt = pend_val_r;

    wr        = 1'b0;
    waddr     = '0;
    mem_rd_en = 1'b0;
    res       = '0;
    res_v     = 1'b0;

    if (accept) begin
      if (command) begin
        mem_rd_en       = 1'b1;
        waddr           = channel_index[AW-1:0];
        res.result_kind = KIND_READ;
        res_v           = 1'b1;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (rx_byte == cfg.start_byte) begin
              phase_nxt = PH_LABEL;
            end
          end
          PH_LABEL: begin
            label_nxt   = rx_byte;
            quality_nxt = '0;
            changed_nxt = 1'b0;
            block_nxt   = '0;
            mask_nxt    = '0;
            cap_nxt     = '0;
            ser_nxt     = '0;
            pos_nxt     = '0;
            phase_nxt   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_nxt   = {8'd0, rx_byte};
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_nxt   = len_full;
            phase_nxt = (len_full == 16'd0) ? PH_END : PH_BODY;
          end
          PH_BODY: begin
            case (label_r)
              LBL_FRAME: begin
                if (pos_r == 16'd0) begin
                  quality_nxt = rx_byte;
                end else if (fslot <= UC16) begin
                  wr    = 1'b1;
                  waddr = fslot[AW-1:0];
                end
              end
              LBL_UPDATE: begin
                if (pos_r == 16'd0) begin
                  block_nxt = rx_byte;
                end else if (pos_r <= 16'(MASK_BYTES)) begin
                  for (int i = 0; i < MASK_BYTES; i++) begin
                    if (pos_r == 16'(i + 1)) begin
                      mask_nxt[8*i +: 8] = mask_r[8*i +: 8] | rx_byte;
                    end
                  end
                end else if (mask_r != '0) begin
                  mask_nxt = mask_r & ~low;
                  if (uslot <= UC12) begin
                    wr    = 1'b1;
                    waddr = uslot[AW-1:0];
                  end
                end
              end
              LBL_CONFIG: begin
                for (int i = 0; i < CONFIG_BYTES; i++) begin
                  if (pos_r == 16'(i)) begin
                    cap_nxt[8*i +: 8] = cap_r[8*i +: 8] | rx_byte;
                  end
                end
              end
              LBL_SERIAL: begin
                for (int i = 0; i < SERIAL_BYTES; i++) begin
                  if (pos_r == 16'(i)) begin
                    ser_nxt[8*(SERIAL_BYTES-1-i) +: 8] =
                      ser_r[8*(SERIAL_BYTES-1-i) +: 8] | rx_byte;
                  end
                end
              end
              default: begin
              end
            endcase
            pos_nxt = pos_inc;
            if (pos_inc == len_r) begin
              phase_nxt = PH_END;
            end
          end
          PH_END: begin
            phase_nxt          = PH_HUNT;
            res.payload_length = len_r;
            case (label_r)
              LBL_FRAME: begin
                res_v                = 1'b1;
                res.result_kind      = KIND_FRAME;
                res.new_data         = changed_cur & (~cfg.filter_enable |
                                       ((quality_r == 8'd0) & (slot0_r == 8'd0)));
                res.rx_quality       = quality_r;
                res.frame_start_code = slot0_r;
              end
              LBL_UPDATE: begin
                res_v           = 1'b1;
                res.result_kind = KIND_UPDATE;
                res.new_data    = 1'b1;
              end
              LBL_CONFIG: begin
                res_v                = 1'b1;
                res.result_kind      = KIND_CONFIG;
                res.firmware_minor   = cap_r[7:0];
                res.firmware_major   = cap_r[15:8];
                res.break_time       = cap_r[23:16];
                res.mark_after_break = cap_r[31:24];
                res.frame_rate       = cap_r[39:32];
              end
              LBL_SERIAL: begin
                res_v = 1'b1;
                if (rx_byte == cfg.end_byte) begin
                  res.result_kind   = KIND_SERIAL;
                  res.serial_number = ser_r;
                end else begin
                  res.result_kind = KIND_ERROR;
                end
              end
              default: begin
                res.payload_length = '0;
              end
            endcase
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end

    if (wr) begin
      mem_rd_en    = 1'b1;
      pend_nxt     = 1'b1;
      pend_val_nxt = rx_byte;
      if (waddr == '0) begin
        slot0_nxt = rx_byte;
      end
    end

    s2_nxt = s2_r;
    if (accept && res_v) begin
      s2_nxt.valid   = 1'b1;
      s2_nxt.chan_rd = command & (channel_index <= UC10);
      s2_nxt.res     = res;
    end else if (adv) begin
      s2_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      label_r    <= '0;
      len_r      <= '0;
      pos_r      <= '0;
      quality_r  <= '0;
      changed_r  <= 1'b0;
      block_r    <= '0;
      mask_r     <= '0;
      cap_r      <= '0;
      ser_r      <= '0;
      slot0_r    <= '0;
      pend_r     <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      label_r    <= label_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      quality_r  <= quality_nxt;
      changed_r  <= changed_nxt;
      block_r    <= block_nxt;
      mask_r     <= mask_nxt;
      cap_r      <= cap_nxt;
      ser_r      <= ser_nxt;
      slot0_r    <= slot0_nxt;
      pend_r     <= pend_nxt;
      s2_r       <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
  end

  assign mem_we    = wr;
  assign mem_addr  = waddr;
  assign mem_wdata = rx_byte;
  assign s2        = s2_r;

endmodule
